// ===== rtl/ugnq_pkg.sv =====
// Package for the uniform grid neighbor query unit.
// Constants and types shared by all rtl modules; no dependencies.
package ugnq_pkg;

    localparam int MAX_POINTS        = 64;
    localparam int IDX_W             = $clog2(MAX_POINTS);
    localparam int MAX_SPAN          = 7;
    localparam int SPAN_W            = $clog2(MAX_SPAN + 1);
    localparam logic [31:0] DEFAULT_CELL_SIZE = 32'd256;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage

// ===== rtl/ugnq_div.sv =====
// Restoring divider, one quotient bit per cycle, floor semantics for signed
// dividends. Depends on ugnq_pkg.
module ugnq_div
    import ugnq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic signed [32:0] quotient,
    output logic               rem_nz
);

    logic [31:0] mag_reg, mag_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] sh;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = 34'd0;
        trial     = 33'd0;
        if (req.start)
        begin
            neg_next  = req.is_signed & req.dividend[31];
            mag_next  = (req.is_signed & req.dividend[31]) ? (~req.dividend + 32'd1)
                                                            : req.dividend;
            d_next    = req.divisor;
            rem_next  = 33'd0;
            q_next    = 32'd0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh    = {rem_reg, mag_reg[31]};
            trial = sh[32:0];
            if (sh[32:0] >= {1'b0, d_reg})
            begin
                trial = sh[32:0] - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[30:0], 1'b0};
            end
            rem_next = trial;
            mag_next = {mag_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign rem_nz = (rem_reg != 33'd0);

    // floor: negative dividend with nonzero remainder rounds down
    always_comb
    begin
        if (neg_reg)
            quotient = -$signed({1'b0, q_reg}) - (rem_nz ? 33'sd1 : 33'sd0);
        else
            quotient = $signed({1'b0, q_reg});
    end
    assign done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_reg)
        else $error("div done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_reg)
        else $error("div did not start");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg != 6'd0)
        else $error("div count underflow");

endmodule

// ===== rtl/ugnq_core.sv =====
// Sequencer: point table memory, insert, clear and cell scan for queries.
// Depends on ugnq_pkg and ugnq_div.
module ugnq_core
    import ugnq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         cell_size,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [IDX_W-1:0]    point_index,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic                keep,
    input  logic [30:0]         radius,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [IDX_W-1:0]    res_index,
    output logic                res_found,
    output logic                res_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_DIVS, S_WRITE, S_CELL, S_RD, S_CHK, S_EMIT, S_FLUSH
    } state_t;

    state_t state_reg;
    logic [1:0]              mode_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [31:0]      py_reg;
    logic [31:0]             rad_reg;
    logic [31:0]             cs_reg;
    logic signed [32:0]      cx_reg, cy_reg;
    logic [SPAN_W-1:0]       span_reg;
    logic signed [SPAN_W+1:0] dx_reg, dy_reg;
    logic [IDX_W:0]          scan_reg;
    logic [IDX_W:0]          nres_reg;
    logic [MAX_POINTS-1:0]   present_reg;
    logic                    pend_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic                    ov_valid_reg, ov_found_reg, ov_last_reg;
    logic [IDX_W-1:0]        ov_idx_reg;

    logic [63:0] cell_mem [MAX_POINTS];
    logic [63:0] rd_reg;
    logic        mem_we;
    logic [63:0] mem_wd;

    div_req_t           dreq;
    logic               ddone;
    logic signed [32:0] dq;
    logic               drem_nz;

    ugnq_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quotient(dq),
                    .rem_nz(drem_nz));

    logic [31:0] cs_act;
    assign cs_act = (cell_size == 32'd0) ? DEFAULT_CELL_SIZE : cell_size;

    logic signed [33:0] tx, ty;
    assign tx = {cx_reg[32], cx_reg} + {{(34-SPAN_W-2){dx_reg[SPAN_W+1]}}, dx_reg};
    assign ty = {cy_reg[32], cy_reg} + {{(34-SPAN_W-2){dy_reg[SPAN_W+1]}}, dy_reg};
    logic match;
    assign match = ($signed(rd_reg[63:32]) == ty) && ($signed(rd_reg[31:0]) == tx);

    logic ov_free;
    assign ov_free  = !ov_valid_reg || res_ready;
    assign in_ready = (state_reg == S_IDLE);

    logic hit;
    logic ov_load;
    assign hit     = present_reg[scan_reg[IDX_W-1:0]] && match
                     && nres_reg != (IDX_W+1)'(MAX_POINTS);
    assign ov_load = ov_free && (((state_reg == S_EMIT) && hit && pend_reg)
                                 || (state_reg == S_FLUSH));

    always_comb
    begin
        mem_we = (state_reg == S_WRITE);
        mem_wd = {cy_reg[31:0], cx_reg[31:0]};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[idx_reg] <= mem_wd;
        rd_reg <= cell_mem[scan_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        dreq = '0;
        if (state_reg == S_IDLE && in_valid
            && (mode == MODE_INSERT || mode == MODE_QUERY))
        begin
            dreq.start     = (mode == MODE_QUERY) || keep;
            dreq.is_signed = 1'b1;
            dreq.dividend  = pos_x;
            dreq.divisor   = cs_act;
        end
        else if (state_reg == S_DIVX && ddone)
        begin
            dreq.start     = 1'b1;
            dreq.is_signed = 1'b1;
            dreq.dividend  = py_reg;
            dreq.divisor   = cs_reg;
        end
        else if (state_reg == S_DIVY && ddone && mode_reg == MODE_QUERY)
        begin
            dreq.start     = 1'b1;
            dreq.is_signed = 1'b0;
            dreq.dividend  = rad_reg;
            dreq.divisor   = cs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            present_reg  <= '0;
            ov_valid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (ov_valid_reg && res_ready && !ov_load)
                ov_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg <= mode;
                        idx_reg  <= point_index;
                        py_reg   <= pos_y;
                        rad_reg  <= {1'b0, radius};
                        cs_reg   <= cs_act;
                        case (mode)
                            MODE_CLEAR:  present_reg <= '0;
                            MODE_INSERT: if (keep) state_reg <= S_DIVX;
                            MODE_QUERY:  state_reg <= S_DIVX;
                            default:     ;
                        endcase
                    end
                end
                S_DIVX:
                    if (ddone)
                    begin
                        cx_reg    <= dq;
                        state_reg <= S_DIVY;
                    end
                S_DIVY:
                    if (ddone)
                    begin
                        cy_reg    <= dq;
                        state_reg <= (mode_reg == MODE_QUERY) ? S_DIVS : S_WRITE;
                    end
                S_DIVS:
                    if (ddone)
                    begin
                        // ceil = floor + (remainder != 0)
                        if (dq > $signed(33'(MAX_SPAN))
                            || (dq == $signed(33'(MAX_SPAN)) && drem_nz))
                            span_reg <= SPAN_W'(MAX_SPAN);
                        else
                            span_reg <= SPAN_W'(dq + (drem_nz ? 33'sd1 : 33'sd0));
                        state_reg <= S_CELL;
                        nres_reg  <= '0;
                        pend_reg  <= 1'b0;
                    end
                S_WRITE:
                begin
                    present_reg[idx_reg] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_CELL:
                begin
                    dy_reg    <= -$signed({2'b0, span_reg});
                    dx_reg    <= -$signed({2'b0, span_reg});
                    scan_reg  <= '0;
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= S_CHK;
                S_CHK:
                    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (ov_free)
                    begin
                        if (hit)
                        begin
                            if (pend_reg)
                            begin
                                ov_valid_reg <= 1'b1;
                                ov_idx_reg   <= pend_idx_reg;
                                ov_found_reg <= 1'b1;
                                ov_last_reg  <= 1'b0;
                            end
                            pend_reg     <= 1'b1;
                            pend_idx_reg <= scan_reg[IDX_W-1:0];
                            nres_reg     <= nres_reg + 1'b1;
                        end
                        if (scan_reg == (IDX_W+1)'(MAX_POINTS - 1))
                        begin
                            scan_reg <= '0;
                            if (dx_reg == $signed({2'b0, span_reg}))
                            begin
                                dx_reg <= -$signed({2'b0, span_reg});
                                if (dy_reg == $signed({2'b0, span_reg}))
                                    state_reg <= S_FLUSH;
                                else
                                begin
                                    dy_reg    <= dy_reg + 1'b1;
                                    state_reg <= S_RD;
                                end
                            end
                            else
                            begin
                                dx_reg    <= dx_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        else
                        begin
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_FLUSH:
                    if (ov_free)
                    begin
                        ov_valid_reg <= 1'b1;
                        ov_idx_reg   <= pend_reg ? pend_idx_reg : '0;
                        ov_found_reg <= pend_reg;
                        ov_last_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = ov_valid_reg;
    assign res_index = ov_idx_reg;
    assign res_found = ov_found_reg;
    assign res_last  = ov_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_valid_reg && !res_ready) |=> (ov_valid_reg && $stable(ov_idx_reg)))
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> present_reg[$past(idx_reg)])
        else $error("insert not recorded");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_found) |-> res_last)
        else $error("empty result not last");

endmodule

// ===== rtl/uniform_grid_neighbor_query_unit.sv =====
// Insert with keep set runs two floor divisions (x then y), then writes the point.
// Query: three divisions, then a scan of every stored slot in each cell,
// (2*span+1)^2 * MAX_POINTS slots, through the single point table read port.
// One request at a time. Reset clears the grid and cell_size; cell memory is
// undefined until written. Top level; depends on ugnq_pkg and ugnq_core.
module uniform_grid_neighbor_query_unit
    import ugnq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic               keep,
    input  logic [30:0]        radius,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         found_index,
    output logic               found,
    output logic               last
);

    logic [31:0] cell_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_size_reg <= 32'd0;
        else if (cfg_we)
            cell_size_reg <= cfg_wdata;
    end

    ugnq_core u_core (
        .clk(clk), .rst_n(rst_n), .cell_size(cell_size_reg),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .point_index(point_index), .pos_x(pos_x), .pos_y(pos_y),
        .keep(keep), .radius(radius),
        .res_valid(out_valid), .res_ready(out_ready),
        .res_index(found_index), .res_found(found), .res_last(last)
    );

endmodule
